@@ rtl/assert_macros.svh @@
// Assertion macros shared by the keyword lexer checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high
`define KWL_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high
`define KWL_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/kwl_pkg.sv @@
// Shared constants, types and word-table functions for the keyword lexer.
// No dependencies; imported by every RTL module and the checker.
`default_nettype none

package kwl_pkg;

   localparam int MAX_TOKEN_LEN = 255;
   localparam int PREFIX_CHARS  = 8;
   localparam int LEN_W         = $clog2(MAX_TOKEN_LEN + 1);
   localparam int PIDX_W        = $clog2(PREFIX_CHARS);
   localparam int OUT_LEN_MAX   = 255;
   localparam int WORD_CHARS    = 8;
   localparam int WORD_COUNT    = 11;
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      TK_PROGRAM    = 4'd0,
      TK_KEYWORD    = 4'd1,
      TK_OPERATOR   = 4'd2,
      TK_NUMBER     = 4'd3,
      TK_IDENTIFIER = 4'd4,
      TK_ASSIGN     = 4'd5,
      TK_LIBRARY    = 4'd6,
      TK_COMMA      = 4'd7,
      TK_SEMICOLON  = 4'd8,
      TK_LPAREN     = 4'd9,
      TK_RPAREN     = 4'd10,
      TK_LBRACE     = 4'd11,
      TK_RBRACE     = 4'd12,
      TK_INVALID    = 4'd13
   } token_kind_type;

   typedef logic [3:0] word_code_type;
   localparam word_code_type WC_NONE = 4'd0;

   // Open-run state, one-hot
   typedef enum logic [2:0] {
      RUN_NONE   = 3'b001,
      RUN_LETTER = 3'b010,
      RUN_DIGIT  = 3'b100
   } run_mode_type;

   // Element k holds character k of the run
   typedef logic [PREFIX_CHARS-1:0][7:0] prefix_type;
   // Element 0 is the leftmost character of a space-padded literal
   typedef logic [0:WORD_CHARS-1][7:0] word_text_type;

   localparam word_text_type WORD_TEXT [WORD_COUNT] = '{
      "program ", "var     ", "if      ", "while   ", "equal   ", "notequal",
      "and     ", "or      ", "advance ", "turn    ", "color   "
   };
   localparam logic [3:0] WORD_LEN [WORD_COUNT] = '{
      4'd7, 4'd3, 4'd2, 4'd5, 4'd5, 4'd8, 4'd3, 4'd2, 4'd7, 4'd4, 4'd5
   };
   localparam token_kind_type WORD_KIND [WORD_COUNT] = '{
      TK_PROGRAM, TK_KEYWORD, TK_KEYWORD, TK_KEYWORD, TK_OPERATOR, TK_OPERATOR,
      TK_OPERATOR, TK_OPERATOR, TK_LIBRARY, TK_LIBRARY, TK_LIBRARY
   };

   // One queue entry: everything one text byte produces
   typedef struct packed {
      logic                 has_run;      // a run closes on this byte
      logic                 run_letter;
      prefix_type           run_prefix;
      logic [LEN_W-1:0]     run_len;
      logic                 has_single;   // a one-character token follows
      token_kind_type       single_kind;
      logic [7:0]           single_byte;
   } tok_entry_type;

   // One result beat
   typedef struct packed {
      token_kind_type       kind;
      word_code_type        code;
      logic [7:0]           char_byte;
      logic [7:0]           len;
      logic                 last;
   } rsp_beat_type;

   // Token kind of a byte that is not a letter, digit or whitespace
   function automatic token_kind_type classify_char(input logic [7:0] b);
      token_kind_type k;
      case (b)
         8'h2C:   k = TK_COMMA;
         8'h3B:   k = TK_SEMICOLON;
         8'h28:   k = TK_LPAREN;
         8'h29:   k = TK_RPAREN;
         8'h7B:   k = TK_LBRACE;
         8'h7D:   k = TK_RBRACE;
         8'h2B:   k = TK_OPERATOR;
         8'h2D:   k = TK_OPERATOR;
         8'h2A:   k = TK_OPERATOR;
         8'h2F:   k = TK_OPERATOR;
         8'h3D:   k = TK_ASSIGN;
         default: k = TK_INVALID;
      endcase
      return k;
   endfunction

   // Parallel compare of a closed letter run against the word table
   function automatic word_code_type match_word(input prefix_type p,
                                                input logic [LEN_W-1:0] len);
      word_code_type code;
      logic          hit;
      code = WC_NONE;
      for (int i = 0; i < WORD_COUNT; i++) begin
         hit = (len == LEN_W'(WORD_LEN[i]));
         for (int k = 0; k < WORD_CHARS; k++) begin
            if ((k < int'(WORD_LEN[i])) && (p[k] != WORD_TEXT[i][k]))
               hit = 1'b0;
         end
         if (hit && (code == WC_NONE))
            code = 4'(i + 1);
      end
      return code;
   endfunction

   // Reported length saturates at the width of the result field
   function automatic logic [7:0] out_len(input logic [LEN_W-1:0] l);
      logic [7:0] r;
      if (int'(l) > OUT_LEN_MAX)
         r = 8'(OUT_LEN_MAX);
      else
         r = 8'(l);
      return r;
   endfunction

endpackage

`default_nettype wire

@@ rtl/kwl_if.sv @@
// Valid/ready channel interfaces for the keyword lexer: text bytes in,
// tokens out. No dependencies.
`default_nettype none

interface kwl_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface kwl_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] token_kind;
   logic [3:0] word_code;
   logic [7:0] token_char;
   logic [7:0] token_length;
   logic       last;

   modport source (output valid, output token_kind, output word_code,
                   output token_char, output token_length, output last, input ready);
   modport sink   (input valid, input token_kind, input word_code,
                   input token_char, input token_length, input last, output ready);
endinterface

`default_nettype wire

@@ rtl/kwl_front.sv @@
// Front end: takes one text byte per beat, tracks the open run and
// classifies the byte into a queue entry. Depends on kwl_pkg, kwl_if.
`default_nettype none

module kwl_front import kwl_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   kwl_req_if.sink      req,
   input  wire logic    q_full,
   output logic         push_valid,
   output tok_entry_type push_entry
);

   run_mode_type     mode_ff, mode_in;
   prefix_type       prefix_ff, prefix_in, prefix_upd;
   logic [LEN_W-1:0] len_ff, len_in, len_upd;

   logic accept;
   logic is_letter, is_digit, is_space, run_open, run_cont;
   logic [7:0] b;

   assign req.ready = !q_full;
   assign accept    = req.valid && !q_full;
   assign b         = req.text_byte;

   // Byte classes
   always_comb begin
      is_letter = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A));
      is_digit  = (b >= 8'h30) && (b <= 8'h39);
      is_space  = (b == 8'h20) || (b == 8'h09) || (b == 8'h0A);
      run_open  = (mode_ff == RUN_LETTER) || (mode_ff == RUN_DIGIT);
      run_cont  = ((mode_ff == RUN_LETTER) && is_letter) ||
                  ((mode_ff == RUN_DIGIT) && is_digit);
   end

   // Run extended by this byte
   always_comb begin
      prefix_upd = prefix_ff;
      if (int'(len_ff) < PREFIX_CHARS)
         prefix_upd[len_ff[PIDX_W-1:0]] = b;
      if (len_ff < LEN_W'(MAX_TOKEN_LEN))
         len_upd = len_ff + LEN_W'(1);
      else
         len_upd = len_ff;
   end

   // Next run state and queue entry
   always_comb begin
      mode_in   = mode_ff;
      prefix_in = prefix_ff;
      len_in    = len_ff;

      push_entry.has_run     = 1'b0;
      push_entry.run_letter  = (mode_ff == RUN_LETTER);
      push_entry.run_prefix  = prefix_ff;
      push_entry.run_len     = len_ff;
      push_entry.has_single  = 1'b0;
      push_entry.single_kind = classify_char(b);
      push_entry.single_byte = b;

      if (run_cont) begin
         prefix_in = prefix_upd;
         len_in    = len_upd;
         if (req.end_of_text) begin
            push_entry.has_run    = 1'b1;
            push_entry.run_prefix = prefix_upd;
            push_entry.run_len    = len_upd;
            mode_in               = RUN_NONE;
            len_in                = '0;
         end
      end else begin
         push_entry.has_run = run_open;
         if (is_letter || is_digit) begin
            if (req.end_of_text) begin
               // one-character run closed at once: never a reserved word
               push_entry.has_single  = 1'b1;
               push_entry.single_kind = is_letter ? TK_IDENTIFIER : TK_NUMBER;
               push_entry.single_byte = 8'h00;
               mode_in                = RUN_NONE;
               len_in                 = '0;
            end else begin
               mode_in      = is_letter ? RUN_LETTER : RUN_DIGIT;
               prefix_in[0] = b;
               len_in       = LEN_W'(1);
            end
         end else begin
            push_entry.has_single = !is_space;
            mode_in               = RUN_NONE;
            len_in                = '0;
         end
      end
   end

   assign push_valid = accept && (push_entry.has_run || push_entry.has_single);

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= RUN_NONE;
         len_ff  <= '0;
      end else if (accept) begin
         mode_ff <= mode_in;
         len_ff  <= len_in;
      end
   end

   // Prefix characters
   always_ff @(posedge clock) begin
      if (accept)
         prefix_ff <= prefix_in;
   end

endmodule

`default_nettype wire

@@ rtl/kwl_queue.sv @@
// Short queue of classified entries between front and back end.
// Depends on kwl_pkg.
`default_nettype none

module kwl_queue import kwl_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           push_valid,
   input  wire tok_entry_type  push_entry,
   output logic                full,
   input  wire logic           pop,
   output logic                head_valid,
   output tok_entry_type       head_entry
);

   tok_entry_type       store_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                do_push, do_pop;

   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = store_ff[rd_ptr_ff];
   assign do_push    = push_valid && !full;
   assign do_pop     = pop && head_valid;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop)
         count_in = count_ff + (QPTR_W+1)'(1);
      else if (do_pop && !do_push)
         count_in = count_ff - (QPTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (do_push)
         store_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

`default_nettype wire

@@ rtl/kwl_back.sv @@
// Back end: matches closed runs against the word table and sends one or
// two result beats per queue entry through an output register.
// Depends on kwl_pkg, kwl_if.
`default_nettype none

module kwl_back import kwl_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           head_valid,
   input  wire tok_entry_type  head_entry,
   output logic                pop,
   kwl_rsp_if.source           rsp
);

   logic         out_valid_ff, out_valid_in;
   rsp_beat_type out_beat_ff, beat_in;
   logic         phase_ff, phase_in;   // run token of the head already sent
   logic         load, on_run, is_last;
   word_code_type code;

   assign load    = head_valid && (!out_valid_ff || rsp.ready);
   assign on_run  = head_entry.has_run && !phase_ff;
   assign is_last = !on_run || !head_entry.has_single;
   assign pop     = load && is_last;

   // Build the beat for the current slot of the head entry
   always_comb begin
      code = head_entry.run_letter ?
             match_word(head_entry.run_prefix, head_entry.run_len) : WC_NONE;
      if (on_run) begin
         beat_in.code      = code;
         if (code != WC_NONE)
            beat_in.kind = WORD_KIND[4'(code - 4'd1)];
         else
            beat_in.kind = head_entry.run_letter ? TK_IDENTIFIER : TK_NUMBER;
         beat_in.char_byte = 8'h00;
         beat_in.len       = out_len(head_entry.run_len);
      end else begin
         beat_in.kind      = head_entry.single_kind;
         beat_in.code      = WC_NONE;
         beat_in.char_byte = head_entry.single_byte;
         beat_in.len       = 8'd1;
      end
      beat_in.last = is_last;
   end

   // Output register and slot pointer
   always_comb begin
      out_valid_in = out_valid_ff;
      phase_in     = phase_ff;
      if (load) begin
         out_valid_in = 1'b1;
         phase_in     = !is_last;
      end else if (rsp.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         phase_ff     <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load)
         out_beat_ff <= beat_in;
   end

   assign rsp.valid        = out_valid_ff;
   assign rsp.token_kind   = out_beat_ff.kind;
   assign rsp.word_code    = out_beat_ff.code;
   assign rsp.token_char   = out_beat_ff.char_byte;
   assign rsp.token_length = out_beat_ff.len;
   assign rsp.last         = out_beat_ff.last;

endmodule

`default_nettype wire

@@ rtl/keyword_token_lexer_top.sv @@
// Top level of the keyword lexer: front end, entry queue, back end.
// Depends on kwl_pkg, kwl_if, kwl_front, kwl_queue, kwl_back.
//
//   channel    dir  beat                                    handshake
//   req_chan   in   text_byte, end_of_text                  valid/ready
//   rsp_chan   out  token_kind, word_code, token_char,      valid/ready
//                   token_length, last
//
// One text byte is taken per cycle while the entry queue has room.
// Each byte gives zero, one or two result beats; the output register sends
// one beat per cycle while rsp_chan.ready is high, so a byte that both closes
// a run and is a token holds the back end for both of its beats.
// Synchronous active-high reset clears run state, queue and output valid.
// A stalled result side fills the four-entry queue, then req_chan.ready drops.

`default_nettype none

module keyword_token_lexer_top import kwl_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   kwl_req_if.sink   req_chan,
   kwl_rsp_if.source rsp_chan
);

   logic          push_valid, q_full, pop, head_valid;
   tok_entry_type push_entry, head_entry;

   kwl_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_chan),
      .q_full     (q_full),
      .push_valid (push_valid),
      .push_entry (push_entry)
   );

   kwl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   kwl_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp        (rsp_chan)
   );

endmodule

`default_nettype wire

@@ rtl/kwl_checker.sv @@
// Port-level assertions on the lexer result channel, bound to the top.
// Depends on kwl_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"

module kwl_checker import kwl_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [3:0] rsp_token_kind,
   input wire logic [3:0] rsp_word_code,
   input wire logic [7:0] rsp_token_char,
   input wire logic [7:0] rsp_token_length,
   input wire logic       rsp_last
);

   // a stalled beat stays put
   `KWL_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_token_kind) && $stable(rsp_word_code) && $stable(rsp_token_char) && $stable(rsp_token_length) && $stable(rsp_last), "rsp beat changed while stalled")

   // only a closed run can be followed by a second beat
   `KWL_ASSERT_IMP(a_first_is_run, clock, reset, rsp_valid && !rsp_last, rsp_token_char == 8'h00 && rsp_token_length != 8'h00, "non-final beat is not a run token")

   // reserved words carry no character and only word kinds
   `KWL_ASSERT_IMP(a_word_kind, clock, reset, rsp_valid && rsp_word_code != WC_NONE, rsp_token_char == 8'h00 && (rsp_token_kind == TK_PROGRAM || rsp_token_kind == TK_KEYWORD || rsp_token_kind == TK_OPERATOR || rsp_token_kind == TK_LIBRARY), "word code on a non-word token")

   // comma, semicolon, assign and invalid tokens are length one and always final
   `KWL_ASSERT_IMP(a_single_len, clock, reset, rsp_valid && (rsp_token_kind == TK_COMMA || rsp_token_kind == TK_SEMICOLON || rsp_token_kind == TK_ASSIGN || rsp_token_kind == TK_INVALID), rsp_token_length == 8'd1 && rsp_last, "bad one-character token")

endmodule

bind keyword_token_lexer_top kwl_checker u_kwl_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_chan.valid),
   .rsp_ready        (rsp_chan.ready),
   .rsp_token_kind   (rsp_chan.token_kind),
   .rsp_word_code    (rsp_chan.word_code),
   .rsp_token_char   (rsp_chan.token_char),
   .rsp_token_length (rsp_chan.token_length),
   .rsp_last         (rsp_chan.last)
);

`default_nettype wire
